FILE: rtl/pti_pkg.sv
// Shared types, constants and helper functions of the particle table integrator.
package pti_pkg;

    localparam int SLOTS_DEFAULT      = 64;
    localparam int TYPE_COUNT_DEFAULT = 16;

    // One stored particle, kept as a single memory word.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        life_left;
        logic [30:0]        life_total;
        logic [30:0]        size;
        logic [31:0]        col_s;
        logic [31:0]        col_e;
        logic [3:0]         ptype;
    } entry_t;

    typedef enum logic [1:0] {
        KIND_SPAWN  = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_EMPTY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_GRAVITY    = 3'd0,
        CFG_WIND_X     = 3'd1,
        CFG_WIND_Y     = 3'd2,
        CFG_WIND_Z     = 3'd3,
        CFG_STEP_SCALE = 3'd4,
        CFG_RUN_ENABLE = 3'd5
    } cfg_idx_t;

    // Micro-steps of the integration sequence, one shared multiply each.
    typedef enum logic [3:0] {
        STEP_GRAV = 4'd0,
        STEP_VY_G = 4'd1,
        STEP_VX_W = 4'd2,
        STEP_VY_W = 4'd3,
        STEP_VZ_W = 4'd4,
        STEP_VX_D = 4'd5,
        STEP_VY_D = 4'd6,
        STEP_VZ_D = 4'd7,
        STEP_PX   = 4'd8,
        STEP_PY   = 4'd9,
        STEP_PZ   = 4'd10,
        STEP_BX   = 4'd11,
        STEP_BY   = 4'd12,
        STEP_BZ   = 4'd13
    } step_t;

    typedef struct packed {
        logic signed [17:0] grav;
        logic [16:0]        drag;
        logic [16:0]        bnc;
    } type_rom_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  latch;
        logic  spawn_wr;
        logic  dt_ld;
        logic  cnt_clr;
        logic  ld_adv;
        logic  kill;
        logic  mul;
        logic  acc;
        logic  clr_py;
        logic  wr_back;
        logic  emit_clr;
        logic  ld_rd;
        logic  div_step;
        logic  mix;
        logic  out_valid;
        logic  emit_inc;
        step_t step;
        kind_t out_kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic live_cur;
        logic bad_type;
        logic full;
        logic op_tick;
        logic run;
        logic died;
        logic bounce;
        logic count_zero;
        logic last_rec;
    } sts_t;

    function automatic type_rom_t type_rom(input logic [3:0] t);
        type_rom_t r;
        case (t)
            4'd0:    r = '{grav:  18'sd32768, drag: 17'd655,  bnc: 17'd19661};
            4'd1:    r = '{grav: -18'sd13107, drag: 17'd3277, bnc: 17'd0};
            4'd2:    r = '{grav:  18'sd6554,  drag: 17'd1966, bnc: 17'd0};
            4'd3:    r = '{grav: -18'sd19661, drag: 17'd2621, bnc: 17'd0};
            4'd4:    r = '{grav: -18'sd6554,  drag: 17'd1311, bnc: 17'd0};
            4'd5:    r = '{grav:  18'sd65536, drag: 17'd655,  bnc: 17'd32768};
            4'd6:    r = '{grav:  18'sd65536, drag: 17'd655,  bnc: 17'd39322};
            4'd7:    r = '{grav: -18'sd32768, drag: 17'd1311, bnc: 17'd0};
            4'd8:    r = '{grav:  18'sd0,     drag: 17'd0,    bnc: 17'd0};
            4'd9:    r = '{grav:  18'sd52429, drag: 17'd1311, bnc: 17'd0};
            4'd10:   r = '{grav:  18'sd19661, drag: 17'd1966, bnc: 17'd0};
            4'd11:   r = '{grav:  18'sd65536, drag: 17'd1311, bnc: 17'd19661};
            4'd12:   r = '{grav:  18'sd52429, drag: 17'd1966, bnc: 17'd13107};
            4'd13:   r = '{grav:  18'sd0,     drag: 17'd655,  bnc: 17'd0};
            4'd14:   r = '{grav:  18'sd0,     drag: 17'd655,  bnc: 17'd0};
            default: r = '{grav: -18'sd6554,  drag: 17'd0,    bnc: 17'd0};
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/pti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pti_ctrl.sv
// Controller state machine: sequences spawn, integration pass and report pass.
module pti_ctrl #(
    parameter int SLOTS = pti_pkg::SLOTS_DEFAULT,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pti_pkg::sts_t    sts,
    output pti_pkg::cmd_t    cmd,
    output logic [IDX_W-1:0] slot
);

    localparam int DIV_STEPS = 17;

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_DEC    = 18'h00002,
        S_SCAN   = 18'h00004,
        S_SP_OUT = 18'h00008,
        S_REJ    = 18'h00010,
        S_T_INIT = 18'h00020,
        S_A_RD   = 18'h00040,
        S_A_LD   = 18'h00080,
        S_A_MUL  = 18'h00100,
        S_A_ACC  = 18'h00200,
        S_A_WR   = 18'h00400,
        S_R_STRT = 18'h00800,
        S_R_RD   = 18'h01000,
        S_R_LD   = 18'h02000,
        S_R_DIV  = 18'h04000,
        S_R_MIX  = 18'h08000,
        S_R_OUT  = 18'h10000,
        S_NONE   = 18'h20000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    pti_pkg::step_t     step_reg, step_next;
    logic [4:0]         div_reg, div_next;
    logic               slot_last;

    assign slot_last = (slot_reg == IDX_W'(SLOTS - 1));

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        step_next    = step_reg;
        div_next     = div_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        cmd.out_kind = pti_pkg::KIND_SPAWN;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                slot_next = '0;
                if (sts.op_tick)
                begin
                    state_next = S_T_INIT;
                end else if (sts.bad_type || sts.full)
                begin
                    state_next = S_REJ;
                end else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!sts.live_cur)
                begin
                    cmd.spawn_wr = 1'b1;
                    state_next   = S_SP_OUT;
                end else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_SP_OUT:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_kind  = pti_pkg::KIND_SPAWN;
                state_next    = S_IDLE;
            end
            S_REJ:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_kind  = pti_pkg::KIND_REJECT;
                state_next    = S_IDLE;
            end
            S_T_INIT:
            begin
                cmd.dt_ld = 1'b1;
                slot_next = '0;
                if (sts.run)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_A_RD;
                end else
                begin
                    state_next = S_R_STRT;
                end
            end
            S_A_RD:
            begin
                if (sts.live_cur)
                begin
                    state_next = S_A_LD;
                end else if (slot_last)
                begin
                    state_next = S_R_STRT;
                end else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_A_LD:
            begin
                cmd.ld_adv = 1'b1;
                if (sts.died)
                begin
                    cmd.kill = 1'b1;
                    if (slot_last)
                    begin
                        state_next = S_R_STRT;
                    end else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = S_A_RD;
                    end
                end else
                begin
                    step_next  = pti_pkg::STEP_GRAV;
                    state_next = S_A_MUL;
                end
            end
            S_A_MUL:
            begin
                if (step_reg == pti_pkg::STEP_BX && !sts.bounce)
                begin
                    state_next = S_A_WR;
                end else
                begin
                    cmd.mul    = 1'b1;
                    cmd.clr_py = (step_reg == pti_pkg::STEP_BX);
                    state_next = S_A_ACC;
                end
            end
            S_A_ACC:
            begin
                cmd.acc = 1'b1;
                if (step_reg == pti_pkg::STEP_BZ)
                begin
                    state_next = S_A_WR;
                end else
                begin
                    step_next  = pti_pkg::step_t'(step_reg + 4'd1);
                    state_next = S_A_MUL;
                end
            end
            S_A_WR:
            begin
                cmd.wr_back = 1'b1;
                if (slot_last)
                begin
                    state_next = S_R_STRT;
                end else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_R_STRT:
            begin
                cmd.emit_clr = 1'b1;
                slot_next    = '0;
                state_next   = sts.count_zero ? S_NONE : S_R_RD;
            end
            S_R_RD:
            begin
                if (sts.live_cur)
                begin
                    state_next = S_R_LD;
                end else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_R_LD:
            begin
                cmd.ld_rd  = 1'b1;
                div_next   = '0;
                state_next = S_R_DIV;
            end
            S_R_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_R_MIX;
                end else
                begin
                    div_next = div_reg + 5'd1;
                end
            end
            S_R_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_R_OUT;
            end
            S_R_OUT:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_kind  = pti_pkg::KIND_RECORD;
                cmd.emit_inc  = 1'b1;
                if (sts.last_rec)
                begin
                    state_next = S_IDLE;
                end else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_R_RD;
                end
            end
            S_NONE:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_kind  = pti_pkg::KIND_EMPTY;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            step_reg  <= pti_pkg::STEP_GRAV;
            div_reg   <= '0;
        end else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            step_reg  <= step_next;
            div_reg   <= div_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign slot = slot_reg;

endmodule

FILE: rtl/pti_dp.sv
// Datapath: configuration, particle table, shared multiplier, divider and mixer.
module pti_dp #(
    parameter int SLOTS      = pti_pkg::SLOTS_DEFAULT,
    parameter int TYPE_COUNT = pti_pkg::TYPE_COUNT_DEFAULT,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pti_pkg::cmd_t      cmd,
    input  logic [IDX_W-1:0]   slot,
    output pti_pkg::sts_t      sts,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [30:0]        init_size,
    input  logic [30:0]        lifetime,
    input  logic [4:0]         ptype,
    input  logic [31:0]        init_color,
    input  logic [31:0]        fade_color,
    output logic [1:0]         kind,
    output logic [5:0]         slot_out,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic [30:0]        cur_size,
    output logic [31:0]        cur_color,
    output logic [6:0]         live_count,
    output logic               last
);

    // floor(x / 15) = (x * RECIP_15) >> 35 for any 32-bit x.
    localparam logic [31:0] RECIP_15    = 32'h88888889;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [16:0] ONE_Q16     = 17'h10000;

    // Configuration registers.
    logic signed [31:0] gravity_reg, wind_x_reg, wind_y_reg, wind_z_reg;
    logic [30:0]        step_scale_reg;
    logic               run_reg;

    // Table control state.
    logic [SLOTS-1:0]   live_reg;
    logic [6:0]         count_reg;
    logic [6:0]         emit_reg;

    // Payload registers.
    pti_pkg::entry_t    lat_reg;
    logic               lat_op_reg;
    logic [4:0]         lat_ptype_reg;
    pti_pkg::entry_t    work_reg;
    logic signed [31:0] g_reg;
    logic [25:0]        dt_reg;
    logic signed [64:0] prod_reg;
    logic [31:0]        rem_reg;
    logic [16:0]        q_reg;
    logic [30:0]        mix_size_reg;
    logic [31:0]        mix_color_reg;

    pti_pkg::entry_t    rdata;
    pti_pkg::entry_t    wdata;
    pti_pkg::entry_t    ld_entry;
    pti_pkg::type_rom_t rom_w;
    logic [60:0]        dt_mul;
    logic signed [32:0] life_new;
    logic signed [32:0] op_a;
    logic signed [31:0] op_b;
    logic signed [31:0] addend;
    logic signed [64:0] prod_sh;
    logic signed [65:0] acc_sum;
    logic signed [31:0] acc_val;
    logic [32:0]        div_diff;
    logic               div_bit;
    logic [31:0]        div_keep;
    logic [16:0]        ratio;
    logic signed [17:0] t_s;
    logic signed [31:0] size_diff;
    logic signed [49:0] size_prod;
    logic signed [50:0] size_sum;
    logic [31:0]        mix_col;
    logic [7:0]         ca, cb;
    logic signed [8:0]  cd;
    logic signed [26:0] cp, cs;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg    <= -32'sd642253;
            wind_x_reg     <= '0;
            wind_y_reg     <= '0;
            wind_z_reg     <= '0;
            step_scale_reg <= 31'd65536;
            run_reg        <= 1'b1;
        end else if (cfg_we)
        begin
            case (cfg_index)
                pti_pkg::CFG_GRAVITY:    gravity_reg    <= cfg_data;
                pti_pkg::CFG_WIND_X:     wind_x_reg     <= cfg_data;
                pti_pkg::CFG_WIND_Y:     wind_y_reg     <= cfg_data;
                pti_pkg::CFG_WIND_Z:     wind_z_reg     <= cfg_data;
                pti_pkg::CFG_STEP_SCALE: step_scale_reg <= cfg_data[30:0];
                pti_pkg::CFG_RUN_ENABLE: run_reg        <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // ---------------- table memory ----------------
    assign wdata = cmd.spawn_wr ? lat_reg : work_reg;

    pti_ram #(
        .WIDTH ($bits(pti_pkg::entry_t)),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.spawn_wr | cmd.wr_back),
        .waddr (slot),
        .wdata (wdata),
        .raddr (slot),
        .rdata (rdata)
    );

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= '0;
            count_reg <= '0;
            emit_reg  <= '0;
        end else
        begin
            if (cmd.spawn_wr)
            begin
                live_reg[slot] <= 1'b1;
            end
            if (cmd.kill)
            begin
                live_reg[slot] <= 1'b0;
            end
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end else if (cmd.spawn_wr || cmd.wr_back)
            begin
                count_reg <= count_reg + 7'd1;
            end
            if (cmd.emit_clr)
            begin
                emit_reg <= '0;
            end else if (cmd.emit_inc)
            begin
                emit_reg <= emit_reg + 7'd1;
            end
        end
    end

    // ---------------- arithmetic ----------------
    // The step length is the scale divided by 4 and then by 15.
    assign dt_mul   = 61'(step_scale_reg[30:2]) * 61'(RECIP_15);
    assign rom_w    = pti_pkg::type_rom(work_reg.ptype);
    assign life_new = $signed({2'b0, rdata.life_left}) - $signed({7'b0, dt_reg});

    always_comb
    begin
        ld_entry           = rdata;
        ld_entry.life_left = life_new[30:0];
    end

    always_comb
    begin
        op_a   = '0;
        op_b   = $signed({6'b0, dt_reg});
        addend = '0;
        case (cmd.step)
            pti_pkg::STEP_GRAV:
            begin
                op_a = 33'(rom_w.grav);
                op_b = gravity_reg;
            end
            pti_pkg::STEP_VY_G:
            begin
                op_a   = 33'(g_reg);
                addend = work_reg.vel_y;
            end
            pti_pkg::STEP_VX_W:
            begin
                op_a   = 33'(wind_x_reg);
                addend = work_reg.vel_x;
            end
            pti_pkg::STEP_VY_W:
            begin
                op_a   = 33'(wind_y_reg);
                addend = work_reg.vel_y;
            end
            pti_pkg::STEP_VZ_W:
            begin
                op_a   = 33'(wind_z_reg);
                addend = work_reg.vel_z;
            end
            pti_pkg::STEP_VX_D:
            begin
                op_a = 33'(work_reg.vel_x);
                op_b = $signed({15'b0, ONE_Q16 - rom_w.drag});
            end
            pti_pkg::STEP_VY_D:
            begin
                op_a = 33'(work_reg.vel_y);
                op_b = $signed({15'b0, ONE_Q16 - rom_w.drag});
            end
            pti_pkg::STEP_VZ_D:
            begin
                op_a = 33'(work_reg.vel_z);
                op_b = $signed({15'b0, ONE_Q16 - rom_w.drag});
            end
            pti_pkg::STEP_PX:
            begin
                op_a   = 33'(work_reg.vel_x);
                addend = work_reg.pos_x;
            end
            pti_pkg::STEP_PY:
            begin
                op_a   = 33'(work_reg.vel_y);
                addend = work_reg.pos_y;
            end
            pti_pkg::STEP_PZ:
            begin
                op_a   = 33'(work_reg.vel_z);
                addend = work_reg.pos_z;
            end
            pti_pkg::STEP_BX:
            begin
                op_a = 33'(work_reg.vel_x);
                op_b = $signed({15'b0, rom_w.bnc});
            end
            pti_pkg::STEP_BY:
            begin
                op_a = -33'(work_reg.vel_y);
                op_b = $signed({15'b0, rom_w.bnc});
            end
            pti_pkg::STEP_BZ:
            begin
                op_a = 33'(work_reg.vel_z);
                op_b = $signed({15'b0, rom_w.bnc});
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign prod_sh = prod_reg >>> 16;
    assign acc_sum = {prod_sh[64], prod_sh} + {{34{addend[31]}}, addend};
    assign acc_val = pti_pkg::sat32(acc_sum);

    // One quotient bit of life_left * 65536 / life_total per cycle.
    assign div_diff = {1'b0, rem_reg} - {2'b0, work_reg.life_total};
    assign div_bit  = !div_diff[32];
    assign div_keep = div_bit ? div_diff[31:0] : rem_reg;

    always_comb
    begin
        if (work_reg.life_total == '0)
        begin
            ratio = '0;
        end else if (q_reg > ONE_Q16)
        begin
            ratio = ONE_Q16;
        end else
        begin
            ratio = q_reg;
        end
        t_s       = $signed({1'b0, ONE_Q16 - ratio});
        size_diff = $signed({2'b0, work_reg.size[30:1]}) - $signed({1'b0, work_reg.size});
        size_prod = size_diff * t_s;
        size_sum  = $signed({20'b0, work_reg.size})
                  + $signed({{17{size_prod[49]}}, size_prod[49:16]});
        mix_col   = '0;
        ca        = '0;
        cb        = '0;
        cd        = '0;
        cp        = '0;
        cs        = '0;
        for (int c = 0; c < 4; c++)
        begin
            ca = work_reg.col_s[8*c +: 8];
            cb = work_reg.col_e[8*c +: 8];
            cd = $signed({1'b0, cb}) - $signed({1'b0, ca});
            cp = cd * t_s;
            cs = $signed({3'b0, ca, 16'b0}) + cp;
            mix_col[8*c +: 8] = cs[23:16];
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            lat_op_reg         <= op;
            lat_ptype_reg      <= ptype;
            lat_reg.pos_x      <= pos_x;
            lat_reg.pos_y      <= pos_y;
            lat_reg.pos_z      <= pos_z;
            lat_reg.vel_x      <= vel_x;
            lat_reg.vel_y      <= vel_y;
            lat_reg.vel_z      <= vel_z;
            lat_reg.life_left  <= lifetime;
            lat_reg.life_total <= lifetime;
            lat_reg.size       <= init_size;
            lat_reg.col_s      <= init_color;
            lat_reg.col_e      <= fade_color;
            lat_reg.ptype      <= ptype[3:0];
        end
        if (cmd.dt_ld)
        begin
            dt_reg <= dt_mul[RECIP_SHIFT +: 26];
        end
        if (cmd.mul)
        begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.ld_adv)
        begin
            work_reg <= ld_entry;
        end else if (cmd.ld_rd)
        begin
            work_reg <= rdata;
        end else if (cmd.acc)
        begin
            case (cmd.step)
                pti_pkg::STEP_GRAV: g_reg          <= acc_val;
                pti_pkg::STEP_VX_W,
                pti_pkg::STEP_VX_D,
                pti_pkg::STEP_BX:   work_reg.vel_x <= acc_val;
                pti_pkg::STEP_VY_G,
                pti_pkg::STEP_VY_W,
                pti_pkg::STEP_VY_D,
                pti_pkg::STEP_BY:   work_reg.vel_y <= acc_val;
                pti_pkg::STEP_VZ_W,
                pti_pkg::STEP_VZ_D,
                pti_pkg::STEP_BZ:   work_reg.vel_z <= acc_val;
                pti_pkg::STEP_PX:   work_reg.pos_x <= acc_val;
                pti_pkg::STEP_PY:   work_reg.pos_y <= acc_val;
                pti_pkg::STEP_PZ:   work_reg.pos_z <= acc_val;
                default:            ;
            endcase
        end else if (cmd.clr_py)
        begin
            work_reg.pos_y <= '0;
        end
        if (cmd.ld_rd)
        begin
            rem_reg <= {1'b0, rdata.life_left};
            q_reg   <= '0;
        end else if (cmd.div_step)
        begin
            rem_reg <= {div_keep[30:0], 1'b0};
            q_reg   <= {q_reg[15:0], div_bit};
        end
        if (cmd.mix)
        begin
            mix_size_reg  <= size_sum[30:0];
            mix_color_reg <= mix_col;
        end
    end

    // ---------------- status ----------------
    assign sts.live_cur   = live_reg[slot];
    assign sts.bad_type   = (lat_ptype_reg >= 5'(TYPE_COUNT));
    assign sts.full       = (count_reg == 7'(SLOTS));
    assign sts.op_tick    = lat_op_reg;
    assign sts.run        = run_reg;
    assign sts.died       = life_new[32] || (life_new == '0);
    assign sts.bounce     = (rom_w.bnc != '0) && work_reg.pos_y[31];
    assign sts.count_zero = (count_reg == '0);
    assign sts.last_rec   = ((emit_reg + 7'd1) == count_reg);

    // ---------------- result fields ----------------
    always_comb
    begin
        kind       = cmd.out_kind;
        live_count = count_reg;
        slot_out   = '0;
        out_pos_x  = '0;
        out_pos_y  = '0;
        out_pos_z  = '0;
        cur_size   = '0;
        cur_color  = '0;
        last       = 1'b1;
        case (cmd.out_kind)
            pti_pkg::KIND_SPAWN:
            begin
                slot_out  = 6'(slot);
                out_pos_x = lat_reg.pos_x;
                out_pos_y = lat_reg.pos_y;
                out_pos_z = lat_reg.pos_z;
                cur_size  = lat_reg.size;
                cur_color = lat_reg.col_s;
            end
            pti_pkg::KIND_RECORD:
            begin
                slot_out  = 6'(slot);
                out_pos_x = work_reg.pos_x;
                out_pos_y = work_reg.pos_y;
                out_pos_z = work_reg.pos_z;
                cur_size  = mix_size_reg;
                cur_color = mix_color_reg;
                last      = sts.last_rec;
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/particle_table_integrator_top.sv
// Top level of the particle table integrator: controller, datapath and ports.
//
// A transaction is accepted on a rising edge with start high and busy low; op
// 0 spawns a particle into the lowest free slot (one result, kind 0, or kind 1
// for a bad type or a full table) and op 1 advances every live particle by one
// sixtieth of the step scale register, when the run enable is set, and streams
// one record per survivor, or a single kind 3 result when none is left. Results
// appear on result_valid for exactly one cycle each and cannot be stalled, so
// the receiver must take every strobe; last marks the final result of a
// transaction and busy stays high until it has gone out. A spawn scans the
// occupied slots ahead of the free one before it writes; a tick decodes, sets
// up the step, integrates the live slots in turn (a dying particle is dropped,
// a bouncing one runs the bounce steps as well), then starts the report pass,
// which skips empty slots and divides and mixes for each record; a tick with
// no survivor ends with its kind 3 result. The per-particle work is paced by
// the single shared 33 x 32 multiplier, which serves the fourteen integration
// steps one at a time, and by the life-ratio divider, which yields one quotient
// bit per cycle for a 17-bit quotient.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// once and belong between transactions. The table needs no clearing pass after
// reset: occupancy is kept in per-slot flip-flops.
module particle_table_integrator_top #(
    parameter int SLOTS      = pti_pkg::SLOTS_DEFAULT,
    parameter int TYPE_COUNT = pti_pkg::TYPE_COUNT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [30:0]        init_size,
    input  logic [30:0]        lifetime,
    input  logic [4:0]         ptype,
    input  logic [31:0]        init_color,
    input  logic [31:0]        fade_color,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [5:0]         slot,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic [30:0]        cur_size,
    output logic [31:0]        cur_color,
    output logic [6:0]         live_count,
    output logic               last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // The controller owns the sequence and the slot pointer; the datapath owns
    // the table, the configuration and all arithmetic.
    pti_pkg::cmd_t    cmd;
    pti_pkg::sts_t    sts;
    logic [IDX_W-1:0] cur_slot;

    pti_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd),
        .slot  (cur_slot)
    );

    pti_dp #(
        .SLOTS      (SLOTS),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .slot        (cur_slot),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .vel_z       (vel_z),
        .init_size   (init_size),
        .lifetime    (lifetime),
        .ptype       (ptype),
        .init_color  (init_color),
        .fade_color  (fade_color),
        .kind        (kind),
        .slot_out    (slot),
        .out_pos_x   (out_pos_x),
        .out_pos_y   (out_pos_y),
        .out_pos_z   (out_pos_z),
        .cur_size    (cur_size),
        .cur_color   (cur_color),
        .live_count  (live_count),
        .last        (last)
    );

    // Each result is shown for the single cycle in which the controller
    // presents it.
    assign result_valid = cmd.out_valid;

endmodule
